// ===== hw/rtl/vmm_pkg.sv =====
// ----------------------------------------------------------------------------
// vmm_pkg
// Shared types and constants for the vector-matrix multiply unit.
// ----------------------------------------------------------------------------
package vmm_pkg;

    // Fixed field widths
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 48;
    localparam int CIDX_W   = 8;
    localparam int CFG_W    = 9;

    // Queue sizing
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } t_reg_idx;

    // Per-request flags set by the front end
    typedef struct packed {
        logic first_row;   // overwrite accumulator
        logic emit;        // last row: produce a result
        logic last_col;    // final column of the product
    } t_flags;

    // One result request
    typedef struct packed {
        logic [CIDX_W-1:0]       column_index;
        logic signed [SUM_W-1:0] sum_value;
        logic                    last_column;
    } t_result;

endpackage

// ===== hw/rtl/vmm_ram.sv =====
// ----------------------------------------------------------------------------
// vmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vmm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read (returns old data on a same-cycle write)
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/vmm_fifo.sv =====
// ----------------------------------------------------------------------------
// vmm_fifo
// Small register FIFO with fill count; head data visible while not empty.
// ----------------------------------------------------------------------------
module vmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [$clog2(DEPTH + 1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/vmm_front.sv =====
// ----------------------------------------------------------------------------
// vmm_front
// Holds size registers, walks row/column position and tags each request.
// ----------------------------------------------------------------------------
module vmm_front #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [vmm_pkg::CFG_W-1:0]          i_cfg_data,
    // Input requests
    input  logic                               i_push,
    input  logic signed [vmm_pkg::VAL_W-1:0]   i_vector_value,
    input  logic signed [vmm_pkg::VAL_W-1:0]   i_matrix_value,
    // Toward middle queue
    input  logic                               i_mid_full,
    output logic                               o_mid_push,
    output logic [2*vmm_pkg::VAL_W + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) + 2:0]
                                               o_mid_data
);

    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWS_RST = ((MAX_ROWS < 256) ? MAX_ROWS : 256) - 1;
    localparam int COLS_RST = ((MAX_COLS < 256) ? MAX_COLS : 256) - 1;

    logic [ROW_W-1:0] r_rows_m1;
    logic [COL_W-1:0] r_cols_m1;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [31:0]      cfg_ext;
    logic [31:0]      cfg_rows_m1;
    logic [31:0]      cfg_cols_m1;
    logic             accept;
    logic             last_row;
    vmm_pkg::t_flags  flags;

    // Clamp written sizes to 1..MAX, stored minus one
    always_comb begin
        cfg_ext = 32'(i_cfg_data);
        if (cfg_ext == 32'd0) begin
            cfg_rows_m1 = 32'd0;
            cfg_cols_m1 = 32'd0;
        end else begin
            cfg_rows_m1 = (cfg_ext > 32'(MAX_ROWS)) ? 32'(MAX_ROWS - 1) : cfg_ext - 32'd1;
            cfg_cols_m1 = (cfg_ext > 32'(MAX_COLS)) ? 32'(MAX_COLS - 1) : cfg_ext - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m1 <= ROW_W'(ROWS_RST);
            r_cols_m1 <= COL_W'(COLS_RST);
        end else if (i_cfg_we) begin
            case (vmm_pkg::t_reg_idx'(i_cfg_index))
                vmm_pkg::REG_NUM_ROWS: r_rows_m1 <= cfg_rows_m1[ROW_W-1:0];
                vmm_pkg::REG_NUM_COLS: r_cols_m1 <= cfg_cols_m1[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // Position tracking
    assign accept   = i_push && !i_mid_full;
    assign last_row = (r_row == r_rows_m1);

    always_comb begin
        flags.first_row = (r_row == '0);
        flags.emit      = last_row;
        flags.last_col  = (r_col == r_cols_m1);
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (flags.last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // A size write restarts the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_we) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_mid_push = accept;
    assign o_mid_data = {i_vector_value, i_matrix_value, r_col, flags};

endmodule

// ===== hw/rtl/vmm_back.sv =====
// ----------------------------------------------------------------------------
// vmm_back
// Multiply-accumulate into per-column sums held in RAM, emits finished sums.
// ----------------------------------------------------------------------------
module vmm_back #(
    parameter int MAX_COLS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // From middle queue
    input  logic                               i_mid_empty,
    input  logic [2*vmm_pkg::VAL_W + ((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1) + 2:0]
                                               i_mid_data,
    output logic                               o_mid_pop,
    // Toward result queue
    input  logic [vmm_pkg::OUT_CNT_W-1:0]      i_out_count,
    output logic                               o_res_push,
    output vmm_pkg::t_result                   o_res_data
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW    = vmm_pkg::OUT_CNT_W + 1;

    // Unpacked head of middle queue
    logic signed [vmm_pkg::VAL_W-1:0]  h_vec;
    logic signed [vmm_pkg::VAL_W-1:0]  h_mat;
    logic [COL_W-1:0]                  h_col;
    vmm_pkg::t_flags                   h_flags;

    // Multiply stage
    logic                              r_s1_valid;
    logic signed [vmm_pkg::PROD_W-1:0] r_s1_prod;
    logic [COL_W-1:0]                  r_s1_col;
    vmm_pkg::t_flags                   r_s1_flags;

    // Last write, for same-column forwarding
    logic                              r_wr_valid;
    logic [COL_W-1:0]                  r_wr_col;
    logic signed [vmm_pkg::SUM_W-1:0]  r_wr_acc;

    logic signed [vmm_pkg::PROD_W-1:0] prod;
    logic [vmm_pkg::SUM_W-1:0]         rd_data;
    logic signed [vmm_pkg::SUM_W-1:0]  base;
    logic signed [vmm_pkg::SUM_W-1:0]  acc;
    logic [CW-1:0]                     used;
    logic                              credit_ok;
    logic [31:0]                       col_ext;

    assign {h_vec, h_mat, h_col, h_flags} = i_mid_data;

    // Reserve result slots for requests in flight
    assign used      = CW'(i_out_count) + CW'(r_s1_valid && r_s1_flags.emit);
    assign credit_ok = (used < CW'(vmm_pkg::OUT_DEPTH));
    assign o_mid_pop = !i_mid_empty && credit_ok;

    assign prod = h_vec * h_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_mid_pop;
            r_wr_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod  <= prod;
        r_s1_col   <= h_col;
        r_s1_flags <= h_flags;
        r_wr_col   <= r_s1_col;
        r_wr_acc   <= acc;
    end

    // Column accumulators
    vmm_ram #(
        .WIDTH (vmm_pkg::SUM_W),
        .DEPTH (MAX_COLS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (acc),
        .i_raddr (h_col),
        .o_rdata (rd_data)
    );

    // Accumulate, forwarding the sum written on the previous cycle
    always_comb begin
        if (r_s1_flags.first_row) begin
            base = '0;
        end else if (r_wr_valid && (r_wr_col == r_s1_col)) begin
            base = r_wr_acc;
        end else begin
            base = rd_data;
        end
        acc = base + {{(vmm_pkg::SUM_W - vmm_pkg::PROD_W){r_s1_prod[vmm_pkg::PROD_W-1]}},
                      r_s1_prod};
    end

    // Result request
    assign col_ext                 = 32'(r_s1_col);
    assign o_res_push              = r_s1_valid && r_s1_flags.emit;
    assign o_res_data.column_index = col_ext[vmm_pkg::CIDX_W-1:0];
    assign o_res_data.sum_value    = acc;
    assign o_res_data.last_column  = r_s1_flags.last_col;

endmodule

// ===== hw/rtl/vector_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// vector_matrix_multiply_unit
// Streaming row vector times matrix product with per-column accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: push a request of {vector_value, matrix_value} while full is
//   low. Matrix elements come in row-major order; each carries the vector
//   element of its row. Values are Q1.15.
//   Result queue: while empty is low the oldest result is on o_column_index,
//   o_sum_value (Q18.30) and o_last_column; pop takes it. Only requests on the
//   last row produce a result; o_last_column marks the final column.
//   Config: i_cfg_we writes num_rows (index 0) or num_cols (index 1); sizes
//   are clamped to 1..MAX and any write restarts the product at row 0.
// Timing:
//   One request per cycle sustained while the result queue has room. A taken
//   request passes through the middle queue, then the multiply register, and
//   is accumulated into the result queue. The column sums live in a RAM with
//   one read and one write port; back-to-back hits on one column are forwarded.
// Reset: counters at zero, sizes at 256 (or MAX), queues empty.
// Stalls: the back end holds requests in the middle queue when the result
//   queue has no free slot, and full rises once that queue fills.
// ----------------------------------------------------------------------------
module vector_matrix_multiply_unit #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [vmm_pkg::CFG_W-1:0]          i_cfg_data,
    // Input queue
    input  logic                               push,
    output logic                               full,
    input  logic signed [vmm_pkg::VAL_W-1:0]   i_vector_value,
    input  logic signed [vmm_pkg::VAL_W-1:0]   i_matrix_value,
    // Result queue
    output logic                               empty,
    input  logic                               pop,
    output logic [vmm_pkg::CIDX_W-1:0]         o_column_index,
    output logic signed [vmm_pkg::SUM_W-1:0]   o_sum_value,
    output logic                               o_last_column
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MID_W = 2 * vmm_pkg::VAL_W + COL_W + 3;
    localparam int RES_W = $bits(vmm_pkg::t_result);

    logic                              mid_push;
    logic [MID_W-1:0]                  mid_wdata;
    logic                              mid_full;
    logic                              mid_pop;
    logic [MID_W-1:0]                  mid_rdata;
    logic                              mid_empty;
    logic                              res_push;
    vmm_pkg::t_result                  res_wdata;
    vmm_pkg::t_result                  res_rdata;
    logic [vmm_pkg::OUT_CNT_W-1:0]     res_count;

    // Front end
    vmm_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .i_vector_value (i_vector_value),
        .i_matrix_value (i_matrix_value),
        .i_mid_full     (mid_full),
        .o_mid_push     (mid_push),
        .o_mid_data     (mid_wdata)
    );

    // Queue between front and back
    vmm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (vmm_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty),
        .o_count ()
    );

    assign full = mid_full;

    // Back end
    vmm_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_rdata),
        .o_mid_pop   (mid_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res_data  (res_wdata)
    );

    // Result queue; slots are reserved by the back end before issue
    vmm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (vmm_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_column_index = res_rdata.column_index;
    assign o_sum_value    = res_rdata.sum_value;
    assign o_last_column  = res_rdata.last_column;

endmodule
